FILE: rtl/tlbfi_pkg.sv
`default_nettype none

package tlbfi_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int PAGE_W      = 20;
  localparam int SLOT_W      = 6;
  localparam int S_TDATA_W   = 48;
  localparam int S_TUSER_W   = 2;
  localparam int M_TDATA_W   = 8;
  localparam int QDEPTH      = 2;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_INVAL_PAGE = 2'd1,
    OP_INVAL_ALL  = 2'd2,
    OP_PROBE      = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PAGE_W-1:0] vp;
    logic [PAGE_W-1:0] pp;
    logic              ro;
  } cmd_t;

  // Stored entry, virtual page in the low bits.
  typedef struct packed {
    logic              writable;
    logic [PAGE_W-1:0] pp;
    logic [PAGE_W-1:0] vp;
  } entry_t;

  // Result item, slot in the low bits.
  typedef struct packed {
    logic              replaced;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/tlbfi_ram.sv
`default_nettype none

module tlbfi_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/tlbfi_front.sv
`default_nettype none

module tlbfi_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [tlbfi_pkg::S_TDATA_W-1:0]        s_tdata,
  input  wire logic [tlbfi_pkg::S_TUSER_W-1:0]        s_tuser,
  output logic                                        cmd_valid,
  input  wire logic                                   cmd_ready,
  output tlbfi_pkg::cmd_t                             cmd
);

  import tlbfi_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             q_mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             in_cmd;
  logic             push;
  logic             pop;

  // Decode the request into a command word.
  always_comb begin
    in_cmd.op = op_t'(s_tuser);
    in_cmd.vp = s_tdata[PAGE_W-1:0];
    in_cmd.pp = s_tdata[2*PAGE_W-1:PAGE_W];
    in_cmd.ro = s_tdata[2*PAGE_W];
  end

  assign s_tready  = (count != CNT_W'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q_mem[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count missed a push");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |=> !$past(pop))
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/tlbfi_back.sv
`default_nettype none

module tlbfi_back #(
  parameter int ENTRIES = tlbfi_pkg::ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire tlbfi_pkg::cmd_t      cmd,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output tlbfi_pkg::res_t           res
);

  import tlbfi_pkg::*;

  localparam int IDXW   = $clog2(ENTRIES);
  localparam int WORD_W = $bits(entry_t);
  localparam logic [IDXW-1:0] LAST = IDXW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t             state, state_next;
  cmd_t               cur, cur_next;
  logic [IDXW-1:0]    cnt, cnt_next;
  logic               issue_done, issue_done_next;
  logic               cmp_vld, cmp_vld_next;
  logic [IDXW-1:0]    cmp_idx, cmp_idx_next;
  logic [ENTRIES-1:0] valid, valid_next;
  logic [IDXW-1:0]    victim, victim_next;
  logic               out_valid, out_valid_next;
  res_t               out_res, out_res_next;

  logic               ram_we;
  logic [IDXW-1:0]    ram_waddr;
  entry_t             ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;
  entry_t             rd_entry;
  logic               match;

  tlbfi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  always_comb begin
    if (cur.op == OP_PROBE) begin
      match = valid[cmp_idx] && (rd_entry.vp == cur.vp);
    end else begin
      match = valid[cmp_idx] && (rd_entry.pp == cur.pp);
    end
  end

  assign cmd_ready = (state == S_IDLE) && !out_valid;
  assign res_valid = out_valid;
  assign res       = out_res;

  always_comb begin
    state_next         = state;
    cur_next           = cur;
    cnt_next           = cnt;
    issue_done_next    = issue_done;
    cmp_vld_next       = 1'b0;
    cmp_idx_next       = cnt;
    valid_next         = valid;
    victim_next        = victim;
    out_valid_next     = out_valid && !res_ready;
    out_res_next       = out_res;
    ram_we             = 1'b0;
    ram_waddr          = cnt;
    ram_wdata.writable = !cur.ro;
    ram_wdata.pp       = cur.pp;
    ram_wdata.vp       = cur.vp;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          cur_next        = cmd;
          cnt_next        = '0;
          issue_done_next = 1'b0;
          unique case (cmd.op)
            OP_INSERT: begin
              state_next = S_INS;
            end
            OP_INVAL_PAGE, OP_PROBE: begin
              state_next = S_SCAN;
            end
            OP_INVAL_ALL: begin
              valid_next     = '0;
              out_valid_next = 1'b1;
              out_res_next   = '0;
            end
          endcase
        end
      end

      S_INS: begin
        if (!valid[cnt]) begin
          ram_we          = 1'b1;
          valid_next[cnt] = 1'b1;
          out_valid_next  = 1'b1;
          out_res_next    = '0;
          out_res_next.slot = SLOT_W'(cnt);
          state_next      = S_IDLE;
        end else if (cnt == LAST) begin
          ram_we             = 1'b1;
          ram_waddr          = victim;
          valid_next[victim] = 1'b1;
          victim_next        = (victim == LAST) ? '0 : victim + IDXW'(1);
          out_valid_next     = 1'b1;
          out_res_next       = '0;
          out_res_next.slot  = SLOT_W'(victim);
          out_res_next.replaced = 1'b1;
          state_next         = S_IDLE;
        end else begin
          cnt_next = cnt + IDXW'(1);
        end
      end

      S_SCAN: begin
        cmp_vld_next = !issue_done;
        if (!issue_done) begin
          if (cnt == LAST) begin
            issue_done_next = 1'b1;
          end else begin
            cnt_next = cnt + IDXW'(1);
          end
        end
        if (cmp_vld) begin
          if (cur.op == OP_PROBE && match) begin
            out_valid_next    = 1'b1;
            out_res_next      = '0;
            out_res_next.slot = SLOT_W'(cmp_idx);
            out_res_next.hit  = 1'b1;
            state_next        = S_IDLE;
          end else begin
            if (cur.op == OP_INVAL_PAGE && match) begin
              valid_next[cmp_idx] = 1'b0;
            end
            if (cmp_idx == LAST) begin
              out_valid_next = 1'b1;
              out_res_next   = '0;
              state_next     = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issue_done <= 1'b0;
      cmp_vld    <= 1'b0;
      valid      <= '0;
      victim     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      issue_done <= issue_done_next;
      cmp_vld    <= cmp_vld_next;
      valid      <= valid_next;
      victim     <= victim_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    cnt     <= cnt_next;
    cmp_idx <= cmp_idx_next;
    out_res <= out_res_next;
  end

`ifndef SYNTH
  a_victim_range: assert property (@(posedge clk) disable iff (rst)
    victim <= LAST)
    else $error("victim pointer out of range");

  a_insert_valid: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && $past(state == S_INS)) |-> valid[out_res.slot[IDXW-1:0]])
    else $error("inserted slot not valid");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && out_res.hit) |-> valid[out_res.slot[IDXW-1:0]])
    else $error("probe hit on invalid slot");

  a_replace_full: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && out_res.replaced) |-> (&valid))
    else $error("replacement while a slot was free");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.hit && out_res.replaced))
    else $error("hit and replaced both set");
`endif

endmodule

`default_nettype wire

FILE: rtl/tlb_fill_and_invalidate_unit.sv
`default_nettype none

// Software-managed translation buffer of ENTRIES entries (2..64). Each request
// item carries an opcode on s_tuser (insert, invalidate by physical page,
// invalidate all, probe) and gives exactly one result item on m_tdata, in
// order. Insert takes the lowest free entry, or, when all are valid, the
// round-robin victim (replaced=1); it does not check for duplicates. Probe
// reports the lowest valid entry whose virtual page matches.
// Timing: requests go into a two-deep queue, so the front keeps taking items
// while the back works or a result waits, as long as the queue has room. The
// back handles one item at a time and walks the entries one per cycle. Insert
// walks the valid bits from entry 0 up to the first free one, or to the last
// entry when full; page invalidate reads every entry; probe reads entries up
// to the first hit, or every entry on a miss. Invalidate all raises m_tvalid
// at the same edge that moves the item out of the queue. The scan for page
// invalidate and probe is set by the single, registered read port of the
// entry RAM. A new item starts only once the previous result has been taken,
// in the cycle after that handshake at the earliest. No clearing pass: valid
// bits sit in flip-flops and reset clears them at once.

module tlb_fill_and_invalidate_unit #(
  parameter int ENTRIES = tlbfi_pkg::ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // virt_page[19:0], phys_page[39:20], read_only[40], zero pad[47:41]
  input  wire logic [tlbfi_pkg::S_TDATA_W-1:0]   s_tdata,
  // opcode[1:0]
  input  wire logic [tlbfi_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // slot[5:0], hit[6], replaced[7]
  output logic [tlbfi_pkg::M_TDATA_W-1:0]        m_tdata
);

  import tlbfi_pkg::*;

  // queue head between front and back
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  tlbfi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // entry walker, valid bits, victim pointer and result register
  tlbfi_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = M_TDATA_W'(res);

endmodule

`default_nettype wire
